### rtl/kvi_pkg.sv
// Shared types, constants and codes of the keyframe interpolator.
`default_nettype none
package kvi_pkg;

  localparam int MAX_KEYS = 64;
  localparam int KEY_AW   = $clog2(MAX_KEYS);
  localparam int CNT_W    = $clog2(MAX_KEYS + 1);
  localparam int TIME_W   = 24;
  localparam int VAL_W    = 24;
  localparam int FRAC_W   = 16;
  localparam int FACT_W   = FRAC_W + 1;
  localparam int CFG_W    = 7;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic ST_OK      = 1'b0;
  localparam logic ST_NO_KEYS = 1'b1;

  localparam logic [FACT_W-1:0] FACTOR_ZERO = '0;
  localparam logic [FACT_W-1:0] FACTOR_ONE  = FACT_W'(1) << FRAC_W;

  typedef struct packed {
    logic                    operation;
    logic [5:0]              key_index;
    logic [TIME_W-1:0]       key_time;
    logic signed [VAL_W-1:0] key_x;
    logic signed [VAL_W-1:0] key_y;
    logic signed [VAL_W-1:0] key_z;
    logic [TIME_W-1:0]       query_time;
  } kvi_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] out_x;
    logic signed [VAL_W-1:0] out_y;
    logic signed [VAL_W-1:0] out_z;
    logic                    status;
  } kvi_out_t;

  typedef struct packed {
    logic [TIME_W-1:0]       key_time;
    logic signed [VAL_W-1:0] key_x;
    logic signed [VAL_W-1:0] key_y;
    logic signed [VAL_W-1:0] key_z;
  } kvi_key_t;

  typedef struct packed {
    logic busy;
    logic done;
  } kvi_div_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_FETCH0,
    S_FETCH1,
    S_FETCH2,
    S_DIFF,
    S_CLASS,
    S_DIV,
    S_MUL,
    S_ACC,
    S_OUT
  } kvi_state_t;

endpackage
`default_nettype wire

### rtl/kvi_key_store.sv
// Keyframe store: one write port, one registered read port.
`default_nettype none
module kvi_key_store (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [kvi_pkg::KEY_AW-1:0] waddr,
  input  wire kvi_pkg::kvi_key_t          wdata,
  input  wire logic [kvi_pkg::KEY_AW-1:0] raddr,
  output kvi_pkg::kvi_key_t               rdata
);

  kvi_pkg::kvi_key_t mem [kvi_pkg::MAX_KEYS];
  kvi_pkg::kvi_key_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### rtl/kvi_divider.sv
// Restoring divider: quotient = (num << 16) / den for num < den, one bit a cycle.
`default_nettype none
module kvi_divider (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [kvi_pkg::TIME_W-1:0] num,
  input  wire logic [kvi_pkg::TIME_W-1:0] den,
  output kvi_pkg::kvi_div_stat_t          stat,
  output logic [kvi_pkg::FRAC_W-1:0]      quotient
);

  localparam int STEP_W = $clog2(kvi_pkg::FRAC_W + 1);

  logic                         busy_r;
  logic                         done_r;
  logic [STEP_W-1:0]            cnt_r;
  logic [kvi_pkg::TIME_W-1:0]   rem_r;
  logic [kvi_pkg::TIME_W-1:0]   den_r;
  logic [kvi_pkg::FRAC_W-1:0]   quo_r;
  logic [kvi_pkg::TIME_W:0]     shifted;
  logic                         fits;

  // remainder stays below the divisor, so the doubled value fits in one extra bit
  assign shifted = {rem_r, 1'b0};
  assign fits    = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= STEP_W'(kvi_pkg::FRAC_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      den_r <= den;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? kvi_pkg::TIME_W'(shifted - {1'b0, den_r})
                    : shifted[kvi_pkg::TIME_W-1:0];
      quo_r <= {quo_r[kvi_pkg::FRAC_W-2:0], fits};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule
`default_nettype wire

### rtl/keyframe_vec3_interpolator_core.sv
// Top level: keyframe track store, segment search and linear interpolation sequencer.
//
//   port group  | dir | handshake            | payload
//   ------------+-----+----------------------+------------------------------
//   in_*        | in  | in_valid / in_ready  | kvi_in_t  (load or query)
//   out_*       | out | out_valid / out_ready| kvi_out_t (one per query)
//   cfg_*       | in  | cfg_we, no wait      | keys_in_use
//
// A load's key is written at the accepting edge.
// A query searches the keys in use through the store's single read port,
// then runs a bit-serial divide where the factor needs one and makes three
// passes through one shared multiplier.
// No keys or one key skip the search; no keys skip the arithmetic as well.
// The result sits in an output register; a new item is taken once it is loaded.
// Reset is synchronous and clears control state and keys_in_use; the store is not cleared.
`default_nettype none
module keyframe_vec3_interpolator_core (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire kvi_pkg::kvi_in_t          in_data,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output kvi_pkg::kvi_out_t              out_data,
  input  wire logic                      cfg_we,
  input  wire logic [kvi_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int VW = kvi_pkg::VAL_W;
  localparam int DW = kvi_pkg::VAL_W + 1;
  localparam int PW = kvi_pkg::FACT_W + 1 + DW;

  kvi_pkg::kvi_state_t           state_r, state_nxt;
  logic [kvi_pkg::CFG_W-1:0]     keys_in_use_r;
  logic [kvi_pkg::CNT_W-1:0]     n_cur;
  logic [kvi_pkg::CNT_W-1:0]     n_r;
  logic [kvi_pkg::CNT_W-1:0]     ptr_r;
  logic [kvi_pkg::CNT_W-1:0]     j_cur;
  logic                          pend_r;
  logic                          one_key_r;
  logic [kvi_pkg::TIME_W-1:0]    q_r;
  logic [kvi_pkg::KEY_AW-1:0]    seg_r;
  logic [kvi_pkg::TIME_W-1:0]    ts_r;
  logic [kvi_pkg::TIME_W-1:0]    te_r;
  logic signed [VW-1:0]          vs_r [3];
  logic signed [VW-1:0]          ve_r [3];
  logic signed [VW-1:0]          res_r [3];
  logic                          status_r;
  logic signed [kvi_pkg::TIME_W:0] num_r, den_r;
  logic [kvi_pkg::TIME_W-1:0]    num_abs, den_abs;
  logic [kvi_pkg::FACT_W-1:0]    factor_r;
  logic [1:0]                    comp_r;
  logic signed [DW-1:0]          diff;
  logic signed [PW-1:0]          prod_r;
  kvi_pkg::kvi_out_t             out_r;
  logic                          out_valid_r;

  logic                          in_acc;
  logic                          is_query;
  logic                          hit;
  logic                          search_end;
  logic                          need_div;
  logic                          out_load;
  logic [kvi_pkg::KEY_AW-1:0]    rd_addr;
  kvi_pkg::kvi_key_t             rd_data;
  kvi_pkg::kvi_key_t             wr_key;
  logic                          wr_en;
  logic                          div_start;
  kvi_pkg::kvi_div_stat_t        div_stat;
  logic [kvi_pkg::FRAC_W-1:0]    div_quo;

  assign in_acc   = in_valid && in_ready;
  assign is_query = in_data.operation == kvi_pkg::OP_QUERY;
  assign n_cur    = (keys_in_use_r > kvi_pkg::CNT_W'(kvi_pkg::MAX_KEYS))
                  ? kvi_pkg::CNT_W'(kvi_pkg::MAX_KEYS)
                  : kvi_pkg::CNT_W'(keys_in_use_r);

  // j is the key whose time is in the read register during the search
  assign j_cur      = ptr_r - kvi_pkg::CNT_W'(1);
  assign hit        = q_r < rd_data.key_time;
  assign search_end = pend_r && (hit || j_cur == n_r - kvi_pkg::CNT_W'(1));

  assign num_abs  = num_r[kvi_pkg::TIME_W] ? kvi_pkg::TIME_W'(-num_r)
                                           : num_r[kvi_pkg::TIME_W-1:0];
  assign den_abs  = den_r[kvi_pkg::TIME_W] ? kvi_pkg::TIME_W'(-den_r)
                                           : den_r[kvi_pkg::TIME_W-1:0];
  assign need_div = !one_key_r && den_r != '0 && num_r != '0
                 && num_r[kvi_pkg::TIME_W] == den_r[kvi_pkg::TIME_W]
                 && num_abs < den_abs;

  assign out_load = !out_valid_r || out_ready;

  // shared multiplier operand; one key means factor zero and nothing to scale
  assign diff = one_key_r ? '0
              : DW'(ve_r[comp_r]) - DW'(vs_r[comp_r]);

  assign wr_en                = in_acc && !is_query
                              && {1'b0, in_data.key_index} < 7'(kvi_pkg::MAX_KEYS);
  assign wr_key.key_time      = in_data.key_time;
  assign wr_key.key_x         = in_data.key_x;
  assign wr_key.key_y         = in_data.key_y;
  assign wr_key.key_z         = in_data.key_z;

  kvi_key_store u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (kvi_pkg::KEY_AW'(in_data.key_index)),
    .wdata (wr_key),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  kvi_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .num      (num_abs),
    .den      (den_abs),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      kvi_pkg::S_IDLE: begin
        if (in_acc && is_query) begin
          if (n_cur == '0) begin
            state_nxt = kvi_pkg::S_OUT;
          end else if (n_cur == kvi_pkg::CNT_W'(1)) begin
            state_nxt = kvi_pkg::S_FETCH0;
          end else begin
            state_nxt = kvi_pkg::S_SEARCH;
          end
        end
      end
      kvi_pkg::S_SEARCH: begin
        if (search_end) state_nxt = kvi_pkg::S_FETCH0;
      end
      kvi_pkg::S_FETCH0: state_nxt = kvi_pkg::S_FETCH1;
      kvi_pkg::S_FETCH1: state_nxt = kvi_pkg::S_FETCH2;
      kvi_pkg::S_FETCH2: state_nxt = kvi_pkg::S_DIFF;
      kvi_pkg::S_DIFF:   state_nxt = kvi_pkg::S_CLASS;
      kvi_pkg::S_CLASS:  state_nxt = need_div ? kvi_pkg::S_DIV : kvi_pkg::S_MUL;
      kvi_pkg::S_DIV: begin
        if (div_stat.done) state_nxt = kvi_pkg::S_MUL;
      end
      kvi_pkg::S_MUL:    state_nxt = kvi_pkg::S_ACC;
      kvi_pkg::S_ACC: begin
        state_nxt = (comp_r == 2'd2) ? kvi_pkg::S_OUT : kvi_pkg::S_MUL;
      end
      kvi_pkg::S_OUT: begin
        if (out_load) state_nxt = kvi_pkg::S_IDLE;
      end
      default: state_nxt = kvi_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    rd_addr   = '0;
    unique case (state_r)
      kvi_pkg::S_IDLE:   in_ready  = 1'b1;
      kvi_pkg::S_SEARCH: rd_addr   = ptr_r[kvi_pkg::KEY_AW-1:0];
      kvi_pkg::S_FETCH0: rd_addr   = seg_r;
      kvi_pkg::S_FETCH1: rd_addr   = seg_r + kvi_pkg::KEY_AW'(1);
      kvi_pkg::S_CLASS:  div_start = need_div;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= kvi_pkg::S_IDLE;
      keys_in_use_r <= '0;
      out_valid_r   <= 1'b0;
      pend_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) keys_in_use_r <= cfg_wdata;
      if (state_r == kvi_pkg::S_OUT && out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      pend_r <= state_r == kvi_pkg::S_SEARCH && !search_end;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      kvi_pkg::S_IDLE: begin
        if (in_acc && is_query) begin
          q_r       <= in_data.query_time;
          n_r       <= n_cur;
          ptr_r     <= kvi_pkg::CNT_W'(1);
          seg_r     <= '0;
          one_key_r <= n_cur == kvi_pkg::CNT_W'(1);
          status_r  <= (n_cur == '0) ? kvi_pkg::ST_NO_KEYS : kvi_pkg::ST_OK;
          for (int c = 0; c < 3; c++) res_r[c] <= '0;
        end
      end
      kvi_pkg::S_SEARCH: begin
        ptr_r <= ptr_r + kvi_pkg::CNT_W'(1);
        if (pend_r && hit) begin
          seg_r <= kvi_pkg::KEY_AW'(ptr_r - kvi_pkg::CNT_W'(2));
        end
      end
      kvi_pkg::S_FETCH1: begin
        ts_r    <= rd_data.key_time;
        vs_r[0] <= rd_data.key_x;
        vs_r[1] <= rd_data.key_y;
        vs_r[2] <= rd_data.key_z;
      end
      kvi_pkg::S_FETCH2: begin
        te_r    <= rd_data.key_time;
        ve_r[0] <= rd_data.key_x;
        ve_r[1] <= rd_data.key_y;
        ve_r[2] <= rd_data.key_z;
      end
      kvi_pkg::S_DIFF: begin
        num_r <= $signed({1'b0, q_r}) - $signed({1'b0, ts_r});
        den_r <= $signed({1'b0, te_r}) - $signed({1'b0, ts_r});
      end
      kvi_pkg::S_CLASS: begin
        comp_r <= '0;
        // zero-length segment and an end already passed both clamp to one
        if (one_key_r) begin
          factor_r <= kvi_pkg::FACTOR_ZERO;
        end else if (den_r == '0) begin
          factor_r <= kvi_pkg::FACTOR_ONE;
        end else if (num_r == '0 || num_r[kvi_pkg::TIME_W] != den_r[kvi_pkg::TIME_W]) begin
          factor_r <= kvi_pkg::FACTOR_ZERO;
        end else if (!need_div) begin
          factor_r <= kvi_pkg::FACTOR_ONE;
        end
      end
      kvi_pkg::S_DIV: begin
        if (div_stat.done) factor_r <= {1'b0, div_quo};
      end
      kvi_pkg::S_MUL: begin
        prod_r <= $signed({1'b0, factor_r}) * diff;
      end
      kvi_pkg::S_ACC: begin
        // arithmetic shift floors; the sum stays between start and end
        res_r[comp_r] <= vs_r[comp_r] + prod_r[kvi_pkg::FRAC_W +: VW];
        comp_r        <= comp_r + 2'd1;
      end
      kvi_pkg::S_OUT: begin
        if (out_load) begin
          out_r.out_x  <= res_r[0];
          out_r.out_y  <= res_r[1];
          out_r.out_z  <= res_r[2];
          out_r.status <= status_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_no_keys_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == kvi_pkg::ST_NO_KEYS
      |-> out_data.out_x == '0 && out_data.out_y == '0 && out_data.out_z == '0)
    else $error("no-key result carries a non-zero value");

  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == kvi_pkg::S_SEARCH && pend_r |-> ptr_r <= n_r)
    else $error("search ran past the keys in use");

  a_factor_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == kvi_pkg::S_MUL |-> factor_r <= kvi_pkg::FACTOR_ONE)
    else $error("interpolation factor above one");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.operation == kvi_pkg::OP_QUERY && keys_in_use_r != '0
      |=> !in_ready)
    else $error("input taken again while a query is in progress");
`endif

endmodule
`default_nettype wire

### verif/tb.sv
// Self-checking testbench for the keyframe track interpolator core.
`timescale 1ns / 1ps

module tb;
  import kvi_pkg::*;

  localparam int ITEMS_TOTAL = 1750;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int SETTLE      = 128;
  localparam int TIME_MAX    = (1 << TIME_W) - 1;
  localparam int CFG_MAX     = (1 << CFG_W) - 1;
  localparam int PRINT_CAP   = 200;

  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  kvi_in_t              in_data;
  logic                 out_valid;
  logic                 out_ready;
  kvi_out_t             out_data;
  logic                 cfg_we;
  logic [CFG_W-1:0]     cfg_wdata;

  // mirror of the block's key store and register
  kvi_key_t             track [MAX_KEYS];
  logic [CFG_W-1:0]     keys_cfg = '0;
  kvi_out_t             expected_samples [$];

  int                   items_sent   = 0;
  int                   samples_seen = 0;
  int                   err_count    = 0;
  int                   cycle_cnt    = 0;
  int                   burst_left   = 0;
  bit                   steady       = 1'b0;
  int                   hold_req     = 0;

  keyframe_vec3_interpolator_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic signed [VAL_W-1:0] lerp(input logic signed [VAL_W-1:0] s,
                                                   input logic signed [VAL_W-1:0] e,
                                                   input longint fct);
    longint d;
    longint r;
    d = longint'(e) - longint'(s);
    // arithmetic shift floors towards minus infinity
    r = longint'(s) + ((fct * d) >>> FRAC_W);
    return r[VAL_W-1:0];
  endfunction

  function automatic kvi_out_t sample_track(input logic [TIME_W-1:0] q);
    kvi_out_t r;
    int       n;
    int       seg;
    bit       found;
    longint   num;
    longint   den;
    longint   a;
    longint   b;
    longint   fct;
    r = '0;
    n = (keys_cfg > MAX_KEYS) ? MAX_KEYS : int'(keys_cfg);
    if (n == 0) begin
      r.status = ST_NO_KEYS;
      return r;
    end
    r.status = ST_OK;
    if (n == 1) begin
      r.out_x = track[0].key_x;
      r.out_y = track[0].key_y;
      r.out_z = track[0].key_z;
      return r;
    end
    seg   = 0;
    found = 1'b0;
    for (int i = 0; i + 1 < n; i++) begin
      if (!found && q < track[i+1].key_time) begin
        seg   = i;
        found = 1'b1;
      end
    end
    num = longint'(q) - longint'(track[seg].key_time);
    den = longint'(track[seg+1].key_time) - longint'(track[seg].key_time);
    if (den == 0) begin
      fct = longint'(FACTOR_ONE);
    end else if (num == 0 || ((num < 0) != (den < 0))) begin
      fct = longint'(FACTOR_ZERO);
    end else begin
      a   = (num < 0) ? -num : num;
      b   = (den < 0) ? -den : den;
      fct = (a >= b) ? longint'(FACTOR_ONE) : (a << FRAC_W) / b;
    end
    r.out_x = lerp(track[seg].key_x, track[seg+1].key_x, fct);
    r.out_y = lerp(track[seg].key_y, track[seg+1].key_y, fct);
    r.out_z = lerp(track[seg].key_z, track[seg+1].key_z, fct);
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                 input logic [VAL_W-1:0] want);
    err_count++;
    // keep the log readable when everything goes wrong
    if (err_count <= PRINT_CAP)
      $display("tb: mismatch on %s, result %0d at %0t: got %h want %h",
               what, samples_seen, $realtime, got, want);
  endtask

  always @(posedge clk) begin
    kvi_out_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      samples_seen++;
      if (expected_samples.size() == 0) begin
        report_mismatch("unexpected result", out_data.out_x, '0);
      end else begin
        want = expected_samples.pop_front();
        if (out_data.out_x !== want.out_x) report_mismatch("out_x", out_data.out_x, want.out_x);
        if (out_data.out_y !== want.out_y) report_mismatch("out_y", out_data.out_y, want.out_y);
        if (out_data.out_z !== want.out_z) report_mismatch("out_z", out_data.out_z, want.out_z);
        if (out_data.status !== want.status)
          report_mismatch("status", VAL_W'(out_data.status), VAL_W'(want.status));
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  initial begin : receiver
    int mode;
    int left;
    int hold_left;
    int phase;
    out_ready = 1'b0;
    mode      = 0;
    left      = 0;
    hold_left = 0;
    phase     = 0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(64, 512);
      end
      left--;
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready = 1'b0;
      end else begin
        case (mode)
          0:       out_ready = 1'b1;
          1:       out_ready = 1'($urandom_range(0, 1));
          2:       out_ready = (phase % 8) >= 3;
          default: out_ready = (phase % 4) == 0;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- sender

  function automatic logic signed [VAL_W-1:0] rand_val();
    case ($urandom_range(0, 9))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // fields a beat does not use are filled at random
  function automatic kvi_in_t make_load(input int slot, input int t,
                                        input logic signed [VAL_W-1:0] x,
                                        input logic signed [VAL_W-1:0] y,
                                        input logic signed [VAL_W-1:0] z);
    kvi_in_t it;
    it.operation  = OP_LOAD;
    it.key_index  = 6'(slot);
    it.key_time   = TIME_W'(t);
    it.key_x      = x;
    it.key_y      = y;
    it.key_z      = z;
    it.query_time = TIME_W'($urandom);
    return it;
  endfunction

  function automatic kvi_in_t make_query(input logic [TIME_W-1:0] qt);
    kvi_in_t it;
    it.operation  = OP_QUERY;
    it.key_index  = 6'($urandom);
    it.key_time   = TIME_W'($urandom);
    it.key_x      = VAL_W'($urandom);
    it.key_y      = VAL_W'($urandom);
    it.key_z      = VAL_W'($urandom);
    it.query_time = qt;
    return it;
  endfunction

  task automatic send_item(input kvi_in_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = (steady || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid = 1'b1;
    in_data  = it;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    items_sent++;
    if (it.operation == OP_LOAD)
      track[it.key_index] = {it.key_time, it.key_x, it.key_y, it.key_z};
    else
      expected_samples.push_back(sample_track(it.query_time));
    @(negedge clk);
  endtask

  // a load gives no result, so let the block settle once the queue is empty
  task automatic wait_idle();
    in_valid = 1'b0;
    while (expected_samples.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_keys_in_use(input int n);
    wait_idle();
    cfg_we    = 1'b1;
    cfg_wdata = CFG_W'(n);
    @(negedge clk);
    cfg_we    = 1'b0;
    keys_cfg  = CFG_W'(n);
  endtask

  function automatic logic [TIME_W-1:0] pick_query_time(input int eff);
    int k;
    int lo;
    int hi;
    int t;
    if (eff == 0) return TIME_W'($urandom);
    k  = $urandom_range(0, eff - 1);
    t  = int'(track[k].key_time);
    lo = int'(track[0].key_time);
    hi = int'(track[eff-1].key_time);
    if (lo > hi) begin
      lo = int'(track[eff-1].key_time);
      hi = int'(track[0].key_time);
    end
    lo = (lo > 16) ? lo - 16 : 0;
    hi = (hi < TIME_MAX - 16) ? hi + 16 : TIME_MAX;
    case ($urandom_range(0, 15))
      0:       t = 0;
      1:       t = TIME_MAX;
      2:       t = int'($urandom_range(0, TIME_MAX));
      3, 4:    ;                      // exactly on a key
      5:       t = t - 1;
      6:       t = t + 1;
      default: t = int'($urandom_range(lo, hi));
    endcase
    if (t < 0) t = 0;
    if (t > TIME_MAX) t = TIME_MAX;
    return TIME_W'(t);
  endfunction

  // mostly rising times, now and then a repeat or a step back
  task automatic load_track(input int cnt);
    int t;
    int span;
    span = $urandom_range(0, 1) ? $urandom_range(1, 'h100) : $urandom_range('h100, 'h3FFFF);
    t    = ($urandom_range(0, 7) == 0) ? $urandom_range(0, TIME_MAX) : $urandom_range(0, 'h1000);
    for (int k = 0; k < cnt; k++) begin
      send_item(make_load(k, t, rand_val(), rand_val(), rand_val()));
      case ($urandom_range(0, 15))
        0:       ;
        1:       t = t - int'($urandom_range(1, span));
        default: t = t + int'($urandom_range(1, span));
      endcase
      if (t < 0) t = 0;
      if (t > TIME_MAX) t = TIME_MAX;
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_empty_track();
    send_item(make_query('0));
    send_item(make_query(TIME_W'(TIME_MAX)));
  endtask

  task automatic test_single_key();
    send_item(make_load(0, TIME_MAX, VAL_MIN, VAL_MAX, '0));
    set_keys_in_use(1);
    send_item(make_query('0));
    send_item(make_query(TIME_W'(TIME_MAX)));
  endtask

  // zero-length first segment, a long middle one, last key out of order
  task automatic test_short_track();
    send_item(make_load(0, 'h000400, VAL_MIN, VAL_MAX, '0));
    send_item(make_load(1, 'h000400, VAL_MAX, VAL_MIN, 24'sd12345));
    send_item(make_load(2, 'h00F000, VAL_MIN, VAL_MIN, VAL_MAX));
    send_item(make_load(3, 'h000800, '0, 24'sd1, -24'sd1));
    set_keys_in_use(4);
    send_item(make_query(24'h000000));
    send_item(make_query(24'h000400));
    send_item(make_query(24'h007A00));
    send_item(make_query(24'h00EFFF));
    send_item(make_query(TIME_W'(TIME_MAX)));
  endtask

  // falling segment: clamp to one, a true fraction, and opposite signs
  task automatic test_reversed_segment();
    send_item(make_load(0, 'h800000, VAL_MAX, VAL_MIN, 24'sd1));
    send_item(make_load(1, 'h000000, VAL_MIN, VAL_MAX, -24'sd1));
    set_keys_in_use(2);
    send_item(make_query(24'h000000));
    send_item(make_query(24'h400000));
    send_item(make_query(TIME_W'(TIME_MAX)));
  endtask

  task automatic test_fill_store();
    load_track(MAX_KEYS);
  endtask

  task automatic test_keys_in_use_extremes();
    int sizes [4];
    sizes = '{0, MAX_KEYS, CFG_MAX, MAX_KEYS + 1};
    foreach (sizes[s]) begin
      set_keys_in_use(sizes[s]);
      repeat (6) send_item(make_query(pick_query_time((sizes[s] > MAX_KEYS) ? MAX_KEYS : sizes[s])));
    end
  endtask

  // receiver holds off for a long stretch while beats keep coming
  task automatic test_output_stall();
    set_keys_in_use(MAX_KEYS);
    steady   = 1'b1;
    hold_req = 600;
    repeat (24) send_item(make_query(pick_query_time(MAX_KEYS)));
    steady   = 1'b0;
  endtask

  task automatic test_random_tracks();
    int n;
    int eff;
    int k;
    while (items_sent < ITEMS_TOTAL) begin
      case ($urandom_range(0, 9))
        0:       n = 0;
        1:       n = 1;
        2:       n = 2;
        3:       n = MAX_KEYS;
        4:       n = $urandom_range(MAX_KEYS + 1, CFG_MAX);
        default: n = $urandom_range(2, 16);
      endcase
      eff = (n > MAX_KEYS) ? MAX_KEYS : n;
      set_keys_in_use(n);
      if ($urandom_range(0, 3) != 0) load_track(eff);
      repeat ($urandom_range(10, 40)) begin
        case ($urandom_range(0, 15))
          0: send_item(make_load($urandom_range(0, MAX_KEYS - 1), $urandom_range(0, TIME_MAX),
                                 rand_val(), rand_val(), rand_val()));
          1: begin
            // new value, same time: keeps the track in order
            k = (eff > 1) ? $urandom_range(0, eff - 1) : 0;
            send_item(make_load(k, int'(track[k].key_time), rand_val(), rand_val(), rand_val()));
          end
          default: send_item(make_query(pick_query_time(eff)));
        endcase
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_empty_track();
    test_single_key();
    test_short_track();
    test_reversed_segment();
    test_fill_store();
    test_keys_in_use_extremes();
    test_output_stall();
    test_random_tracks();

    wait_idle();
    if (err_count == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
